// ----- src/fsct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsct_pkg
// Shared types, constants and the wrap-around run search of the segment
// corner test.
// ----------------------------------------------------------------------------
package fsct_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int RING_POINTS    = 16;
  localparam int COMPASS_POINTS = 4;
  localparam int COMPASS_STEP   = RING_POINTS / COMPASS_POINTS;
  localparam int GROUP_SIZE     = 4;
  localparam int GROUPS         = RING_POINTS / GROUP_SIZE;
  localparam int DIFF_BITS      = PIXEL_BITS;
  localparam int PART_BITS      = DIFF_BITS + $clog2(GROUP_SIZE);
  localparam int SCORE_BITS     = 12;
  localparam int LEN_BITS       = 5;
  localparam int CFG_BITS       = 8;
  localparam int INDEX_BITS     = 2;
  localparam int WORD_BITS      = PIXEL_BITS * RING_POINTS / 2;

  localparam logic [LEN_BITS-1:0] PRETEST_LENGTH = LEN_BITS'(12);
  localparam logic [LEN_BITS-1:0] MAX_LENGTH     = LEN_BITS'(RING_POINTS);

  localparam logic [PIXEL_BITS-1:0] THRESHOLD_RESET = PIXEL_BITS'(20);

  typedef enum logic [INDEX_BITS-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SEGMENT   = 2'd1,
    REG_PRETEST   = 2'd2
  } reg_index_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [DIFF_BITS-1:0]  diff_t;
  typedef logic [PART_BITS-1:0]  part_t;

  typedef struct packed {
    logic                   valid;
    logic [RING_POINTS-1:0] bright;
    logic [RING_POINTS-1:0] dark;
  } lane_flags_t;

  // Window ANDs of lengths 1, 2, 4, 8, 16 are combined by the bits of the
  // length, each placed after the windows already taken.
  function automatic logic has_run(input logic [RING_POINTS-1:0] mask,
                                   input logic [LEN_BITS-1:0] len);
    logic [LEN_BITS-1:0]      l;
    logic [RING_POINTS-1:0]   w [LEN_BITS];
    logic [RING_POINTS-1:0]   acc;
    logic [LEN_BITS-1:0]      off;
    logic [2*RING_POINTS-1:0] dbl;
    l = (len > MAX_LENGTH) ? MAX_LENGTH : len;
    w[0] = mask;
    for (int b = 1; b < LEN_BITS; b++) begin
      dbl  = {w[b-1], w[b-1]};
      w[b] = w[b-1] & dbl[(1 << (b - 1)) +: RING_POINTS];
    end
    acc = '1;
    off = '0;
    for (int b = 0; b < LEN_BITS; b++) begin
      if (l[b]) begin
        dbl = {w[b], w[b]};
        acc = acc & dbl[off[LEN_BITS-2:0] +: RING_POINTS];
        off = off + LEN_BITS'(1 << b);
      end
    end
    return |acc;
  endfunction

endpackage

// ----- src/fsct_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsct_lane
// One ring pixel: brighter and darker flags against the band around the
// centre, and the absolute difference from the centre, registered.
// ----------------------------------------------------------------------------
module fsct_lane (
  input  logic                                   clk,
  input  logic [fsct_pkg::PIXEL_BITS-1:0]        pixel,
  input  logic [fsct_pkg::PIXEL_BITS-1:0]        center,
  input  logic [fsct_pkg::PIXEL_BITS-1:0]        threshold,
  output logic                                   bright,
  output logic                                   dark,
  output logic [fsct_pkg::DIFF_BITS-1:0]         diff
);
  import fsct_pkg::*;

  logic [PIXEL_BITS:0] upper;
  logic [PIXEL_BITS:0] pixel_plus;
  logic                bright_next;
  logic                dark_next;
  diff_t               diff_next;

  always_comb begin
    upper       = {1'b0, center} + {1'b0, threshold};
    pixel_plus  = {1'b0, pixel} + {1'b0, threshold};
    bright_next = {1'b0, pixel} > upper;
    dark_next   = pixel_plus < {1'b0, center};
    diff_next   = (pixel > center) ? DIFF_BITS'(pixel - center)
                                   : DIFF_BITS'(center - pixel);
  end

  always_ff @(posedge clk) begin
    bright <= bright_next;
    dark   <= dark_next;
    diff   <= diff_next;
  end

endmodule

// ----- src/fsct_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsct_merge
// Combines the lane results: compass pre-test, contiguous run search and
// score sum, over two register stages.
// ----------------------------------------------------------------------------
module fsct_merge (
  input  logic                                    clk,
  input  logic                                    rst,
  input  fsct_pkg::lane_flags_t                   flags,
  input  fsct_pkg::diff_t                         diff [fsct_pkg::RING_POINTS],
  input  logic [fsct_pkg::LEN_BITS-1:0]           segment_length,
  input  logic                                    full_pretest_enable,
  output logic                                    done,
  output logic                                    is_corner,
  output logic [fsct_pkg::SCORE_BITS-1:0]         corner_score
);
  import fsct_pkg::*;

  logic                       mid_valid;
  logic                       mid_corner;
  part_t                      mid_part [GROUPS];
  logic                       corner_next;
  part_t                      part_next [GROUPS];
  logic [COMPASS_POINTS-1:0]  cb;
  logic [COMPASS_POINTS-1:0]  cd;
  logic [SCORE_BITS-1:0]      score_next;

  always_comb begin
    for (int k = 0; k < COMPASS_POINTS; k++) begin
      cb[k] = flags.bright[k * COMPASS_STEP];
      cd[k] = flags.dark[k * COMPASS_STEP];
    end
    corner_next = has_run(flags.bright, segment_length) ||
                  has_run(flags.dark, segment_length);
    if (segment_length == PRETEST_LENGTH) begin
      if (full_pretest_enable && ((~(cb | cd)) != '0)) begin
        corner_next = 1'b0;
      end
      if (($countones(cb) < 3) && ($countones(cd) < 3)) begin
        corner_next = 1'b0;
      end
    end
    for (int g = 0; g < GROUPS; g++) begin
      part_next[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        part_next[g] = part_next[g] + PART_BITS'(diff[g * GROUP_SIZE + j]);
      end
    end
    score_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      score_next = score_next + SCORE_BITS'(mid_part[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      mid_valid <= flags.valid;
      done      <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid_corner   <= corner_next;
    mid_part     <= part_next;
    is_corner    <= mid_corner;
    corner_score <= mid_corner ? score_next : '0;
  end

endmodule

// ----- src/fast_segment_corner_test_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_segment_corner_test_unit
// FAST segment test on a 16-pixel ring: sixteen pixel lanes feed a merge
// stage that applies the compass pre-test, run search and score sum.
// Start passes the lane valid register and the two merge stages to reach the done strobe.
// Throughput: one transaction per clock; busy stays low, set by the lanes
// and two merge stages all advancing every cycle.
// Reset: clears the pipeline valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module fast_segment_corner_test_unit (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  output logic                                         busy,
  input  logic [fsct_pkg::PIXEL_BITS-1:0]              center_value,
  input  logic [fsct_pkg::WORD_BITS-1:0]               ring_low,
  input  logic [fsct_pkg::WORD_BITS-1:0]               ring_high,
  input  logic                                         cfg_write,
  input  logic [fsct_pkg::INDEX_BITS-1:0]              cfg_index,
  input  logic [fsct_pkg::CFG_BITS-1:0]                cfg_data,
  output logic                                         done,
  output logic                                         is_corner,
  output logic [fsct_pkg::SCORE_BITS-1:0]              corner_score
);
  import fsct_pkg::*;

  logic [PIXEL_BITS-1:0]        band_threshold;
  logic [LEN_BITS-1:0]          segment_length;
  logic                         full_pretest_enable;
  logic                         lane_valid;
  logic [RING_POINTS-1:0]       lane_bright;
  logic [RING_POINTS-1:0]       lane_dark;
  lane_flags_t                  flags;
  diff_t                        diff [RING_POINTS];
  logic [2*WORD_BITS-1:0]       ring;

  assign busy = 1'b0;
  assign ring = {ring_high, ring_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      band_threshold      <= THRESHOLD_RESET;
      segment_length      <= PRETEST_LENGTH;
      full_pretest_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: band_threshold      <= cfg_data[PIXEL_BITS-1:0];
        REG_SEGMENT:   segment_length      <= cfg_data[LEN_BITS-1:0];
        REG_PRETEST:   full_pretest_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else begin
      lane_valid <= start && !busy;
    end
  end

  assign flags = '{valid: lane_valid, bright: lane_bright, dark: lane_dark};

  for (genvar k = 0; k < RING_POINTS; k++) begin : g_lane
    fsct_lane u_lane (
      .clk       (clk),
      .pixel     (ring[k*PIXEL_BITS +: PIXEL_BITS]),
      .center    (center_value),
      .threshold (band_threshold),
      .bright    (lane_bright[k]),
      .dark      (lane_dark[k]),
      .diff      (diff[k])
    );
  end

  fsct_merge u_merge (
    .clk                 (clk),
    .rst                 (rst),
    .flags               (flags),
    .diff                (diff),
    .segment_length      (segment_length),
    .full_pretest_enable (full_pretest_enable),
    .done                (done),
    .is_corner           (is_corner),
    .corner_score        (corner_score)
  );

endmodule

// ----- src/fsct_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsct_checker
// Port-level checks of the corner test unit: fixed latency and result
// consistency.
// ----------------------------------------------------------------------------
module fsct_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic                                 done,
  input  logic                                 is_corner,
  input  logic [fsct_pkg::SCORE_BITS-1:0]      corner_score
);
  import fsct_pkg::*;

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("transaction result missing three cycles after start");

  a_no_orphan : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("done strobe without a matching transaction");

  a_zero_score : assert property (@(posedge clk) disable iff (rst)
    (done && !is_corner) |-> (corner_score == '0))
    else $error("nonzero score on a non-corner result");

  a_never_busy : assert property (@(posedge clk) disable iff (rst)
    start |=> !busy)
    else $error("busy raised");

endmodule

bind fast_segment_corner_test_unit fsct_checker u_fsct_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .is_corner    (is_corner),
  .corner_score (corner_score)
);

// ----- test/fast_segment_corner_test_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_segment_corner_test_unit_tb
// Self-checking bench for the 16-pixel ring corner test. Each accepted
// transaction is judged by a local model of the brighter and darker bands,
// the compass pre-test, the wrap-around run search and the score sum. Each
// done strobe is compared with the oldest pending verdict. Directed tests
// cover the register extremes and the corner cases. Random phases follow,
// with three levels of sender gaps.
// ----------------------------------------------------------------------------
module fast_segment_corner_test_unit_tb;
  import fsct_pkg::*;

  typedef struct packed {
    logic                  is_corner;
    logic [SCORE_BITS-1:0] score;
  } verdict_t;

  localparam logic [INDEX_BITS-1:0] UNUSED_INDEX = 2'd3;
  localparam int RING_BITS = PIXEL_BITS * RING_POINTS;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  pixel_t                center_value;
  logic [WORD_BITS-1:0]  ring_low;
  logic [WORD_BITS-1:0]  ring_high;
  logic                  cfg_write;
  logic [INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]   cfg_data;
  logic                  done;
  logic                  is_corner;
  logic [SCORE_BITS-1:0] corner_score;

  verdict_t        pending_verdicts[$];
  int              mismatches = 0;
  int              sender_gap_pct = 0;
  logic [7:0]      thr_setting = 8'd20;
  logic [4:0]      seg_setting = 5'd12;
  logic            pretest_setting = 1'b0;

  fast_segment_corner_test_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .center_value (center_value),
    .ring_low     (ring_low),
    .ring_high    (ring_high),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .is_corner    (is_corner),
    .corner_score (corner_score)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic ring_has_run(input logic [RING_POINTS-1:0] mask, input int len);
    int   n;
    logic hit;
    logic found;
    n = (len > RING_POINTS) ? RING_POINTS : len;
    found = 1'b0;
    for (int s = 0; s < RING_POINTS; s++) begin
      hit = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (!mask[(s + j) % RING_POINTS]) hit = 1'b0;
      end
      if (hit) found = 1'b1;
    end
    return found;
  endfunction

  function automatic verdict_t judge_ring(input pixel_t c, input logic [RING_BITS-1:0] ring);
    int                     upper;
    int                     lower;
    int                     p;
    int                     score;
    int                     cb;
    int                     cd;
    int                     pos;
    logic [RING_POINTS-1:0] bright;
    logic [RING_POINTS-1:0] dark;
    logic                   inband;
    logic                   ok;
    verdict_t               v;
    upper = int'(c) + int'(thr_setting);
    lower = int'(c) - int'(thr_setting);
    score = 0;
    for (int k = 0; k < RING_POINTS; k++) begin
      p = int'(ring[PIXEL_BITS*k +: PIXEL_BITS]);
      bright[k] = (p > upper);
      dark[k] = (p < lower);
      score += (p > int'(c)) ? p - int'(c) : int'(c) - p;
    end
    ok = 1'b1;
    if (seg_setting == PRETEST_LENGTH) begin
      cb = 0;
      cd = 0;
      inband = 1'b0;
      for (int q = 0; q < COMPASS_POINTS; q++) begin
        pos = q * COMPASS_STEP;
        cb += int'(bright[pos]);
        cd += int'(dark[pos]);
        if (!bright[pos] && !dark[pos]) inband = 1'b1;
      end
      if (pretest_setting && inband) ok = 1'b0;
      if (cb < 3 && cd < 3) ok = 1'b0;
    end
    if (ok) ok = ring_has_run(bright, int'(seg_setting)) || ring_has_run(dark, int'(seg_setting));
    v.is_corner = ok;
    v.score = ok ? SCORE_BITS'(score) : '0;
    return v;
  endfunction

  function automatic logic [RING_BITS-1:0] paint(input logic [RING_BITS-1:0] ring,
                                                 input int first, input int count,
                                                 input pixel_t v);
    for (int i = 0; i < count; i++) ring[PIXEL_BITS*((first + i) % RING_POINTS) +: PIXEL_BITS] = v;
    return ring;
  endfunction

  function automatic pixel_t outside_band(input pixel_t c, input logic up);
    int t;
    t = int'(thr_setting);
    if (up && int'(c) + t < 255) return pixel_t'($urandom_range(255, int'(c) + t + 1));
    if (!up && int'(c) - t > 0) return pixel_t'($urandom_range(int'(c) - t - 1, 0));
    return pixel_t'($urandom);
  endfunction

  function automatic pixel_t band_edge(input pixel_t c);
    int v;
    case ($urandom_range(5))
      0: v = int'(c) + int'(thr_setting);
      1: v = int'(c) + int'(thr_setting) + 1;
      2: v = int'(c) - int'(thr_setting);
      3: v = int'(c) - int'(thr_setting) - 1;
      4: v = int'(c);
      default: v = int'($urandom_range(255));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pixel_t'(v);
  endfunction

  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    wait_drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: thr_setting = data;
      REG_SEGMENT:   seg_setting = data[LEN_BITS-1:0];
      REG_PRETEST:   pretest_setting = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_item(input pixel_t c, input logic [RING_BITS-1:0] ring);
    while ($urandom_range(99) < sender_gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    center_value <= c;
    ring_low     <= ring[WORD_BITS-1:0];
    ring_high    <= ring[RING_BITS-1:WORD_BITS];
    do @(posedge clk); while (busy !== 1'b0);
    pending_verdicts.insert(pending_verdicts.size(), judge_ring(c, ring));
  endtask

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && done === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected transaction: is_corner=%0b corner_score=%0d", is_corner, corner_score);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (is_corner !== want.is_corner) begin
          $error("is_corner: expected %0b, actual %0b", want.is_corner, is_corner);
          mismatches++;
        end
        if (corner_score !== want.score) begin
          $error("corner_score: expected %0d, actual %0d", want.score, corner_score);
          mismatches++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_item(8'd0, {RING_POINTS{8'hFF}});
    send_item(8'd255, {RING_POINTS{8'h00}});
    send_item(8'd128, {RING_POINTS{8'd128}});
    send_item(8'd100, paint({RING_POINTS{8'd100}}, 0, 12, 8'd200));
    send_item(8'd100, paint({RING_POINTS{8'd100}}, 1, 11, 8'd200));
    send_item(8'd100, paint({RING_POINTS{8'd100}}, 10, 12, 8'd0));
    send_item(8'd100, {RING_POINTS{8'd120}});
    send_item(8'd100, {RING_POINTS{8'd121}});
  endtask

  task automatic test_full_pretest();
    write_reg(REG_PRETEST, 8'd1);
    send_item(8'd100, paint({RING_POINTS{8'd100}}, 0, 12, 8'd200));
    send_item(8'd100, paint(paint({RING_POINTS{8'd100}}, 0, 12, 8'd200), 12, 1, 8'd0));
  endtask

  task automatic test_segment_lengths();
    write_reg(REG_SEGMENT, 8'd0);
    send_item(8'd0, {RING_POINTS{8'h00}});
    write_reg(REG_SEGMENT, 8'd1);
    send_item(8'd50, paint({RING_POINTS{8'd50}}, 7, 1, 8'd255));
    write_reg(REG_SEGMENT, 8'd9);
    send_item(8'd50, paint({RING_POINTS{8'd50}}, 13, 9, 8'd0));
    write_reg(REG_SEGMENT, 8'd16);
    send_item(8'd50, paint({RING_POINTS{8'd50}}, 3, 15, 8'd255));
    write_reg(REG_SEGMENT, 8'd17);
    send_item(8'd50, {RING_POINTS{8'd255}});
    write_reg(REG_SEGMENT, 8'd31);
    send_item(8'd50, paint({RING_POINTS{8'd50}}, 0, 15, 8'd0));
  endtask

  task automatic test_threshold_extremes();
    write_reg(REG_THRESHOLD, 8'd0);
    send_item(8'd100, {RING_POINTS{8'd101}});
    send_item(8'd100, paint({RING_POINTS{8'd101}}, 5, 1, 8'd100));
    write_reg(REG_THRESHOLD, 8'd255);
    write_reg(REG_SEGMENT, 8'd1);
    send_item(8'd0, {RING_POINTS{8'hFF}});
  endtask

  task automatic test_register_masking();
    write_reg(REG_THRESHOLD, 8'd20);
    write_reg(REG_SEGMENT, 8'hEC);
    write_reg(REG_PRETEST, 8'hFE);
    write_reg(UNUSED_INDEX, 8'hFF);
    send_item(8'd100, paint({RING_POINTS{8'd100}}, 0, 12, 8'd200));
  endtask

  task automatic randomize_config();
    logic [7:0] t;
    logic [7:0] s;
    case ($urandom_range(9))
      0:       t = 8'd0;
      1:       t = 8'd255;
      2, 3:    t = 8'($urandom);
      default: t = 8'($urandom_range(60));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: s = 8'd12;
      4, 5, 6:    s = 8'($urandom_range(11, 9));
      default:    s = 8'($urandom);
    endcase
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_SEGMENT, s);
    write_reg(REG_PRETEST, 8'($urandom));
  endtask

  task automatic run_random_phase(input int gap_pct, input int items);
    pixel_t              c;
    logic [RING_BITS-1:0] ring;
    int                  len;
    int                  pick;
    logic                up;
    sender_gap_pct = gap_pct;
    for (int n = 0; n < items; n++) begin
      if (n % 50 == 0) randomize_config();
      c = pixel_t'($urandom);
      ring = {$urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(9);
      if (pick < 6) begin
        up = 1'($urandom_range(1));
        if ($urandom_range(1)) len = int'(seg_setting) + $urandom_range(2) - 1;
        else len = $urandom_range(RING_POINTS, 1);
        if (len < 1) len = 1;
        if (len > RING_POINTS) len = RING_POINTS;
        pick = $urandom_range(RING_POINTS - 1);
        for (int i = 0; i < len; i++) ring = paint(ring, pick + i, 1, outside_band(c, up));
      end else if (pick < 8) begin
        for (int k = 0; k < RING_POINTS; k++) ring = paint(ring, k, 1, band_edge(c));
      end
      send_item(c, ring);
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    center_value = '0;
    ring_low     = '0;
    ring_high    = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sender_gap_pct = 8;
    test_reset_defaults();
    test_full_pretest();
    test_segment_lengths();
    test_threshold_extremes();
    test_register_masking();
    run_random_phase(8, 300);
    run_random_phase(82, 300);
    run_random_phase(0, 300);
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("fast_segment_corner_test_unit regression: pass");
    end else begin
      $display("fast_segment_corner_test_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fast_segment_corner_test_unit regression: fail");
    $finish;
  end

endmodule
